>>> rtl/pip_pkg.sv
`default_nettype none

package pip_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_W      = 16;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int VIDX_W       = 4;
    localparam int VCNT_W       = 5;
    localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W        = ($clog2(MAX_VERTICES + 1) > VCNT_W) ?
                                  $clog2(MAX_VERTICES + 1) : VCNT_W;
    localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(3);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef struct packed {
        logic busy;
        logic toggle_vld;
        logic toggle;
    } edge_stat_t;

endpackage

`default_nettype wire

>>> rtl/pip_vertex_mem.sv
`default_nettype none

module pip_vertex_mem (
    input  wire logic                              clk,
    input  wire logic                              wr_en,
    input  wire logic [pip_pkg::IDX_W-1:0]         wr_addr,
    input  wire logic signed [pip_pkg::COORD_W-1:0] wr_x,
    input  wire logic signed [pip_pkg::COORD_W-1:0] wr_y,
    input  wire logic [pip_pkg::IDX_W-1:0]         rd_addr,
    output logic signed [pip_pkg::COORD_W-1:0]      rd_x,
    output logic signed [pip_pkg::COORD_W-1:0]      rd_y
);

    logic [2*pip_pkg::COORD_W-1:0] mem [pip_pkg::MAX_VERTICES];
    logic [2*pip_pkg::COORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_x, wr_y};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_x = $signed(rd_data_reg[2*pip_pkg::COORD_W-1:pip_pkg::COORD_W]);
    assign rd_y = $signed(rd_data_reg[pip_pkg::COORD_W-1:0]);

endmodule

`default_nettype wire

>>> rtl/pip_edge_unit.sv
`default_nettype none

module pip_edge_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_vld,
    input  wire logic signed [pip_pkg::COORD_W-1:0] px,
    input  wire logic signed [pip_pkg::COORD_W-1:0] py,
    input  wire logic signed [pip_pkg::COORD_W-1:0] xi,
    input  wire logic signed [pip_pkg::COORD_W-1:0] yi,
    input  wire logic signed [pip_pkg::COORD_W-1:0] xj,
    input  wire logic signed [pip_pkg::COORD_W-1:0] yj,
    output pip_pkg::edge_stat_t                     stat
);

    logic                              s1_vld_reg;
    logic                              s1_straddle_reg;
    logic signed [pip_pkg::DIFF_W-1:0] s1_dy_reg;
    logic signed [pip_pkg::DIFF_W-1:0] s1_a_reg;
    logic signed [pip_pkg::DIFF_W-1:0] s1_b_reg;
    logic signed [pip_pkg::DIFF_W-1:0] s1_c_reg;

    logic                              s2_vld_reg;
    logic                              s2_straddle_reg;
    logic                              s2_dy_pos_reg;
    logic signed [pip_pkg::PROD_W-1:0] s2_lhs_reg;
    logic signed [pip_pkg::PROD_W-1:0] s2_rhs_reg;

    logic signed [pip_pkg::DIFF_W-1:0] px_e;
    logic signed [pip_pkg::DIFF_W-1:0] py_e;
    logic signed [pip_pkg::DIFF_W-1:0] xi_e;
    logic signed [pip_pkg::DIFF_W-1:0] yi_e;
    logic signed [pip_pkg::DIFF_W-1:0] xj_e;
    logic signed [pip_pkg::DIFF_W-1:0] yj_e;

    assign px_e = $signed({px[pip_pkg::COORD_W-1], px});
    assign py_e = $signed({py[pip_pkg::COORD_W-1], py});
    assign xi_e = $signed({xi[pip_pkg::COORD_W-1], xi});
    assign yi_e = $signed({yi[pip_pkg::COORD_W-1], yi});
    assign xj_e = $signed({xj[pip_pkg::COORD_W-1], xj});
    assign yj_e = $signed({yj[pip_pkg::COORD_W-1], yj});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // stage 1: side test and differences
    always_ff @(posedge clk)
    begin
        s1_straddle_reg <= (yi > py) != (yj > py);
        s1_dy_reg       <= yj_e - yi_e;
        s1_a_reg        <= px_e - xi_e;
        s1_b_reg        <= xj_e - xi_e;
        s1_c_reg        <= py_e - yi_e;
    end

    // stage 2: cross products
    always_ff @(posedge clk)
    begin
        s2_straddle_reg <= s1_straddle_reg;
        s2_dy_pos_reg   <= !s1_dy_reg[pip_pkg::DIFF_W-1] && (|s1_dy_reg);
        s2_lhs_reg      <= s1_a_reg * s1_dy_reg;
        s2_rhs_reg      <= s1_b_reg * s1_c_reg;
    end

    assign stat.busy       = s1_vld_reg | s2_vld_reg;
    assign stat.toggle_vld = s2_vld_reg;
    assign stat.toggle     = s2_straddle_reg &&
                             (s2_dy_pos_reg ? (s2_lhs_reg < s2_rhs_reg)
                                            : (s2_lhs_reg > s2_rhs_reg));

endmodule

`default_nettype wire

>>> rtl/point_in_polygon_test.sv
`default_nettype none

// channel  | handshake                  | payload
// item     | item_valid / item_stall    | op, vertex_index, x_coord, y_coord
// result   | result_valid / result_stall| inside_res, is_test_result
// config   | cfg_we                     | cfg_wdata (vertex_count)
//
// Load: S_DONE registers the result once the output register is free. Test: n is
// vertex_count capped at 16; S_WALK does n + 1 vertex store reads one per cycle, S_DRAIN
// empties the 2-stage cross-multiply unit, then S_DONE likewise. item_stall is high from
// transfer until the result is handed to the output register. rst_n clears control state
// and sets vertex_count to 3; vertex store contents are undefined until loaded.
// A stalled result holds in the output register; the next item is taken meanwhile.

module point_in_polygon_test (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [pip_pkg::VCNT_W-1:0]          cfg_wdata,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic                                op,
    input  wire logic [pip_pkg::VIDX_W-1:0]          vertex_index,
    input  wire logic signed [pip_pkg::COORD_W-1:0]  x_coord,
    input  wire logic signed [pip_pkg::COORD_W-1:0]  y_coord,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic                                     inside_res,
    output logic                                     is_test_result
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    logic [pip_pkg::VCNT_W-1:0]          vertex_count_reg;
    logic [pip_pkg::CNT_W-1:0]           n_eff;
    logic [pip_pkg::CNT_W-1:0]           rd_cnt_reg, rd_cnt_next;
    logic                                rd_vld_reg, rd_vld_next;
    logic                                rd_first_reg, rd_first_next;
    logic [pip_pkg::IDX_W-1:0]           rd_addr;
    logic signed [pip_pkg::COORD_W-1:0]  px_reg, py_reg;
    logic signed [pip_pkg::COORD_W-1:0]  xj_reg, yj_reg;
    logic signed [pip_pkg::COORD_W-1:0]  mem_x, mem_y;
    logic                                inside_reg, inside_next;
    logic                                is_test_reg, is_test_next;
    logic                                result_valid_reg, result_valid_next;
    logic                                res_inside_reg, res_inside_next;
    logic                                res_is_test_reg, res_is_test_next;
    logic                                accept;
    logic                                wr_en;
    logic                                out_free;
    pip_pkg::edge_stat_t                 edge_stat;

    assign accept   = item_valid && !item_stall;
    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        if (pip_pkg::CNT_W'(vertex_count_reg) > pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES))
        begin
            n_eff = pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES);
        end
        else
        begin
            n_eff = pip_pkg::CNT_W'(vertex_count_reg);
        end
    end

    assign rd_addr = (rd_cnt_reg == '0) ? pip_pkg::IDX_W'(n_eff - pip_pkg::CNT_W'(1))
                                        : pip_pkg::IDX_W'(rd_cnt_reg - pip_pkg::CNT_W'(1));

    assign wr_en = accept && (op == pip_pkg::OP_LOAD) &&
                   (pip_pkg::CNT_W'(vertex_index) < pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES));

    pip_vertex_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pip_pkg::IDX_W'(vertex_index)),
        .wr_x    (x_coord),
        .wr_y    (y_coord),
        .rd_addr (rd_addr),
        .rd_x    (mem_x),
        .rd_y    (mem_y)
    );

    pip_edge_unit u_edge (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (rd_vld_reg && !rd_first_reg),
        .px     (px_reg),
        .py     (py_reg),
        .xi     (mem_x),
        .yi     (mem_y),
        .xj     (xj_reg),
        .yj     (yj_reg),
        .stat   (edge_stat)
    );

    always_comb
    begin
        state_next        = state_reg;
        rd_cnt_next       = rd_cnt_reg;
        rd_vld_next       = 1'b0;
        rd_first_next     = 1'b0;
        inside_next       = inside_reg;
        is_test_next      = is_test_reg;
        result_valid_next = result_valid_reg && result_stall;
        res_inside_next   = res_inside_reg;
        res_is_test_next  = res_is_test_reg;

        if (edge_stat.toggle_vld && edge_stat.toggle)
        begin
            inside_next = !inside_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    inside_next  = 1'b0;
                    is_test_next = (op == pip_pkg::OP_TEST);
                    rd_cnt_next  = '0;
                    if ((op == pip_pkg::OP_TEST) && (n_eff != '0))
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WALK:
            begin
                rd_vld_next   = 1'b1;
                rd_first_next = (rd_cnt_reg == '0);
                rd_cnt_next   = rd_cnt_reg + pip_pkg::CNT_W'(1);
                if (rd_cnt_reg == n_eff)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_vld_reg && !edge_stat.busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    res_inside_next   = inside_reg;
                    res_is_test_next  = is_test_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rd_cnt_reg       <= '0;
            rd_vld_reg       <= 1'b0;
            rd_first_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            vertex_count_reg <= pip_pkg::VCNT_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            rd_cnt_reg       <= rd_cnt_next;
            rd_vld_reg       <= rd_vld_next;
            rd_first_reg     <= rd_first_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                vertex_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        inside_reg      <= inside_next;
        is_test_reg     <= is_test_next;
        res_inside_reg  <= res_inside_next;
        res_is_test_reg <= res_is_test_next;
        if (accept)
        begin
            px_reg <= x_coord;
            py_reg <= y_coord;
        end
        if (rd_vld_reg)
        begin
            xj_reg <= mem_x;
            yj_reg <= mem_y;
        end
    end

    assign item_stall     = (state_reg != S_IDLE);
    assign result_valid   = result_valid_reg;
    assign inside_res     = res_inside_reg;
    assign is_test_result = res_is_test_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("item transfer did not start work");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside completion");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (rd_cnt_reg <= n_eff))
        else $error("edge walk ran past vertex count");

    a_edge_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        edge_stat.busy |-> ((state_reg == S_WALK) || (state_reg == S_DRAIN)))
        else $error("edge unit active outside a test");

endmodule

`default_nettype wire
